// File: sv/vpp_pkg.sv
package vpp_pkg;

  // default component width of the projection datapath
  localparam int COMP_WIDTH_DEF = 16;

  // operand slice width of one hardware multiplier
  localparam int MUL_CHUNK = 32;

  // pipeline depth of the wide multiplier
  localparam int MUL_STAGES = 4;

endpackage

// File: sv/vpp_mul.sv
module vpp_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                        clk_i,
  input  logic [vpp_pkg::MUL_STAGES-1:0] en_i,
  input  logic signed [AW-1:0]        a_i,
  input  logic signed [BW-1:0]        b_i,
  output logic signed [AW+BW-1:0]     p_o
);
  import vpp_pkg::*;

  localparam int C  = MUL_CHUNK;
  localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PW = AW + BW;
  localparam int TW = (NA + NB) * MUL_CHUNK;

  logic [NA*C-1:0]  am_q;
  logic [NB*C-1:0]  bm_q;
  logic [AW-1:0]    a_abs;
  logic [BW-1:0]    b_abs;
  logic [2*C-1:0]   pp_q [NA][NB];
  logic [TW-1:0]    acc;
  logic [PW-1:0]    sum_q;
  logic signed [PW-1:0] p_q;
  logic             s1_q, s2_q, s3_q;

  // stage 1: magnitudes and product sign
  assign a_abs = a_i[AW-1] ? $unsigned(-a_i) : $unsigned(a_i);
  assign b_abs = b_i[BW-1] ? $unsigned(-b_i) : $unsigned(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      am_q <= (NA*C)'(a_abs);
      bm_q <= (NB*C)'(b_abs);
      s1_q <= a_i[AW-1] ^ b_i[BW-1];
    end
  end

  // stage 2: slice products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= am_q[i*C +: C] * bm_q[j*C +: C];
        end
      end
      s2_q <= s1_q;
    end
  end

  // stage 3: weighted sum of slice products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (TW'(pp_q[i][j]) << ((i + j) * C));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum_q <= acc[PW-1:0];
      s3_q  <= s2_q;
    end
  end

  // stage 4: restore sign
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      p_q <= s3_q ? -$signed(sum_q) : $signed(sum_q);
    end
  end

  assign p_o = p_q;

endmodule

// File: sv/vpp_div.sv
module vpp_div #(
  parameter int NW = 84,
  parameter int DW = 67,
  parameter int QB = 18
) (
  input  logic          clk_i,
  input  logic [QB-1:0] en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QB-1:0] q_o
);

  localparam int EW = NW + QB;

  logic [NW-1:0] rem_q [QB];
  logic [DW-1:0] d_q   [QB];
  logic [QB-1:0] q_q   [QB];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QB-1:0] q_in;
    logic [EW-1:0] ds;
    logic [EW-1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = n_i;
      assign d_in   = d_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign d_in   = d_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign ds   = EW'(d_in) << (QB - 1 - k);
    assign ge   = EW'(rem_in) >= ds;
    assign diff = EW'(rem_in) - ds;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= ge ? diff[NW-1:0] : rem_in;
        d_q[k]   <= d_in;
        q_q[k]   <= q_in | (QB'(ge) << (QB - 1 - k));
      end
    end
  end

  assign q_o = q_q[QB-1];

endmodule

// File: sv/vector_project_onto_plane_top.sv
// projects u onto the plane spanned by w and v: five dot products, the gram
// determinant det = aa*bb - ab*ab, and r = (A*w + B*v) / det with exact
// integer products and a truncating division per component; each component
// saturates to the component range (saturated flag) and a zero determinant
// gives a zero result with the degenerate flag. one request is taken every
// cycle while the output is not stalled; the restoring divider resolves one
// quotient bit per pipeline stage (COMP_WIDTH + 2 stages) after two four-stage
// wide multipliers
module vector_project_onto_plane_top #(
  parameter int COMP_WIDTH = vpp_pkg::COMP_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // u_x, u_y, u_z, w_x, w_y, w_z, v_x, v_y, v_z from bit 0 up, zero padded
  input  logic [((9*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // r_x, r_y, r_z from bit 0 up, zero padded
  output logic [((3*COMP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate, saturated from bit 0 up
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);
  import vpp_pkg::*;

  localparam int W   = COMP_WIDTH;
  localparam int DW  = 2*W + 1;       // dot products
  localparam int PW  = 2*DW;          // products of dot products
  localparam int CW  = PW + 1;        // det, A, B
  localparam int MW  = CW + W;        // A*w_i, B*v_i
  localparam int NW  = MW + 1;        // numerators
  localparam int QB  = W + 2;         // quotient bits, |r_i| <= |u| < 2^(W+1)
  localparam int ODW = ((3*COMP_WIDTH+7)/8)*8;

  // pipeline stage numbers
  localparam int ST_IN   = 0;
  localparam int ST_PROD = 1;
  localparam int ST_DOT  = 2;
  localparam int ST_M1   = 3;
  localparam int ST_DIFF = ST_M1 + MUL_STAGES;
  localparam int ST_M2   = ST_DIFF + 1;
  localparam int ST_NUM  = ST_M2 + MUL_STAGES;
  localparam int ST_ABS  = ST_NUM + 1;
  localparam int ST_DIV  = ST_ABS + 1;
  localparam int ST_OUT  = ST_DIV + QB;
  localparam int NS      = ST_OUT + 1;

  typedef struct packed {
    logic [2:0] nneg;
    logic       dneg;
    logic       deg;
  } side_t;

  // stall control: a stage loads when empty or when the next one loads
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~vld_q[NS-1] | m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[ST_IN];

  // input register, w and v delayed up to the second multiplier
  logic signed [W-1:0] u_q [3];
  logic signed [W-1:0] w_q [ST_IN:ST_DIFF][3];
  logic signed [W-1:0] v_q [ST_IN:ST_DIFF][3];

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i]        <= s_axis_tdata[i*W +: W];
        w_q[ST_IN][i] <= s_axis_tdata[(3+i)*W +: W];
        v_q[ST_IN][i] <= s_axis_tdata[(6+i)*W +: W];
      end
    end
    for (int k = ST_IN + 1; k <= ST_DIFF; k++) begin
      if (en[k]) begin
        w_q[k] <= w_q[k-1];
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // component products: aa, ab, ac, bb, bc
  logic signed [2*W-1:0] pr_q [5][3];

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[0][i] <= w_q[ST_IN][i] * w_q[ST_IN][i];
        pr_q[1][i] <= w_q[ST_IN][i] * v_q[ST_IN][i];
        pr_q[2][i] <= w_q[ST_IN][i] * u_q[i];
        pr_q[3][i] <= v_q[ST_IN][i] * v_q[ST_IN][i];
        pr_q[4][i] <= v_q[ST_IN][i] * u_q[i];
      end
    end
  end

  // dot products
  logic signed [DW-1:0] dot_q [5];

  always_ff @(posedge clk_i) begin
    if (en[ST_DOT]) begin
      for (int j = 0; j < 5; j++) begin
        dot_q[j] <= DW'(pr_q[j][0]) + DW'(pr_q[j][1]) + DW'(pr_q[j][2]);
      end
    end
  end

  // aa*bb, ab*ab, ac*bb, bc*ab, aa*bc, ab*ac
  logic signed [DW-1:0] m1_a [6];
  logic signed [DW-1:0] m1_b [6];
  logic signed [PW-1:0] m1_p [6];

  assign m1_a[0] = dot_q[0];
  assign m1_b[0] = dot_q[3];
  assign m1_a[1] = dot_q[1];
  assign m1_b[1] = dot_q[1];
  assign m1_a[2] = dot_q[2];
  assign m1_b[2] = dot_q[3];
  assign m1_a[3] = dot_q[4];
  assign m1_b[3] = dot_q[1];
  assign m1_a[4] = dot_q[0];
  assign m1_b[4] = dot_q[4];
  assign m1_a[5] = dot_q[1];
  assign m1_b[5] = dot_q[2];

  for (genvar j = 0; j < 6; j++) begin : g_m1
    vpp_mul #(
      .AW (DW),
      .BW (DW)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (en[ST_M1 +: MUL_STAGES]),
      .a_i   (m1_a[j]),
      .b_i   (m1_b[j]),
      .p_o   (m1_p[j])
    );
  end

  // determinant and the two plane coefficients
  logic signed [CW-1:0] det_q [ST_DIFF:ST_NUM];
  logic signed [CW-1:0] ca_q;
  logic signed [CW-1:0] cb_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      det_q[ST_DIFF] <= CW'(m1_p[0]) - CW'(m1_p[1]);
      ca_q           <= CW'(m1_p[2]) - CW'(m1_p[3]);
      cb_q           <= CW'(m1_p[4]) - CW'(m1_p[5]);
    end
    for (int k = ST_DIFF + 1; k <= ST_NUM; k++) begin
      if (en[k]) det_q[k] <= det_q[k-1];
    end
  end

  // A*w_i and B*v_i
  logic signed [MW-1:0] m2_p [6];

  for (genvar i = 0; i < 3; i++) begin : g_m2
    vpp_mul #(
      .AW (CW),
      .BW (W)
    ) u_mul_w (
      .clk_i (clk_i),
      .en_i  (en[ST_M2 +: MUL_STAGES]),
      .a_i   (ca_q),
      .b_i   (w_q[ST_DIFF][i]),
      .p_o   (m2_p[i])
    );

    vpp_mul #(
      .AW (CW),
      .BW (W)
    ) u_mul_v (
      .clk_i (clk_i),
      .en_i  (en[ST_M2 +: MUL_STAGES]),
      .a_i   (cb_q),
      .b_i   (v_q[ST_DIFF][i]),
      .p_o   (m2_p[3+i])
    );
  end

  // numerators
  logic signed [NW-1:0] num_q [3];

  always_ff @(posedge clk_i) begin
    if (en[ST_NUM]) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= NW'(m2_p[i]) + NW'(m2_p[3+i]);
      end
    end
  end

  // magnitudes for the divider, signs and the degenerate case ride alongside
  logic [NW-1:0] nmag_q [3];
  logic [CW-1:0] dmag_q;
  side_t         side_q [ST_ABS:ST_OUT-1];

  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      for (int i = 0; i < 3; i++) begin
        nmag_q[i]           <= num_q[i][NW-1] ? $unsigned(-num_q[i]) : $unsigned(num_q[i]);
        side_q[ST_ABS].nneg[i] <= num_q[i][NW-1];
      end
      dmag_q <= det_q[ST_NUM][CW-1] ? $unsigned(-det_q[ST_NUM]) : $unsigned(det_q[ST_NUM]);
      side_q[ST_ABS].dneg <= det_q[ST_NUM][CW-1];
      side_q[ST_ABS].deg  <= (det_q[ST_NUM] == '0);
    end
    for (int k = ST_ABS + 1; k < ST_OUT; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  logic [QB-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vpp_div #(
      .NW (NW),
      .DW (CW),
      .QB (QB)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[ST_DIV +: QB]),
      .n_i   (nmag_q[i]),
      .d_i   (dmag_q),
      .q_o   (quo[i])
    );
  end

  // sign, saturation and the degenerate override
  localparam logic [QB-1:0] HALF = QB'(1) << (W - 1);

  side_t               side_last;
  logic                neg   [3];
  logic [QB-1:0]       lim   [3];
  logic [QB-1:0]       mag   [3];
  logic [QB-1:0]       sres  [3];
  logic [2:0]          clip;
  logic signed [W-1:0] r_q   [3];
  logic                deg_q;
  logic                sat_q;

  assign side_last = side_q[ST_OUT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]  = (side_last.nneg[i] ^ side_last.dneg) && (quo[i] != '0);
      lim[i]  = neg[i] ? HALF : HALF - QB'(1);
      clip[i] = quo[i] > lim[i];
      mag[i]  = clip[i] ? lim[i] : quo[i];
      sres[i] = neg[i] ? -mag[i] : mag[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= side_last.deg ? '0 : sres[i][W-1:0];
      end
      deg_q <= side_last.deg;
      sat_q <= ~side_last.deg & (|clip);
    end
  end

  assign m_axis_tvalid = vld_q[ST_OUT];
  assign m_axis_tdata  = ODW'({r_q[2], r_q[1], r_q[0]});
  assign m_axis_tuser  = {sat_q, deg_q};

endmodule

// File: dv/vector_project_onto_plane_top_test.sv
`timescale 1ns / 1ps

module vector_project_onto_plane_top_test;

  localparam int CW = vpp_pkg::COMP_WIDTH_DEF;
  localparam int IN_W = ((9*CW+7)/8)*8;
  localparam int OUT_W = ((3*CW+7)/8)*8;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = CW + 40;
  localparam int RANDOM_ITEMS = 800;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [CW-1:0] r_z;
    logic          degenerate;
    logic          saturated;
  } proj_t;

  typedef struct {
    logic [IN_W-1:0] data;
    bit              typed;
    proj_t           res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;

  // projections still owed by the block, oldest first
  proj_t owed_q[$];
  row_t  dir_rows[$];

  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_degen = 0;
  int n_clip = 0;
  int idle_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;

  vector_project_onto_plane_top #(.COMP_WIDTH(CW)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // exact projection of u onto span(w, v); 128 bits covers every product
  function automatic proj_t project_plane(logic [IN_W-1:0] d);
    wide_t u[3], w[3], v[3];
    wide_t aa, ab, ac, bb, bc, det, ca, cb, num, quo;
    wide_t hi, lo;
    logic [CW-1:0] comp[3];
    proj_t p;
    hi = (wide_t'(1) <<< (CW-1)) - 1;
    lo = -(wide_t'(1) <<< (CW-1));
    for (int i = 0; i < 3; i++) begin
      u[i] = $signed(d[CW*i +: CW]);
      w[i] = $signed(d[CW*(3+i) +: CW]);
      v[i] = $signed(d[CW*(6+i) +: CW]);
    end
    aa = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
    ab = w[0]*v[0] + w[1]*v[1] + w[2]*v[2];
    ac = w[0]*u[0] + w[1]*u[1] + w[2]*u[2];
    bb = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    bc = v[0]*u[0] + v[1]*u[1] + v[2]*u[2];
    det = aa*bb - ab*ab;
    p = '0;
    if (det == 0) begin
      p.degenerate = 1'b1;
      return p;
    end
    ca = ac*bb - bc*ab;
    cb = aa*bc - ab*ac;
    for (int i = 0; i < 3; i++) begin
      num = ca*w[i] + cb*v[i];
      quo = num / det;  // truncates toward zero
      if (quo > hi) begin
        quo = hi;
        p.saturated = 1'b1;
      end else if (quo < lo) begin
        quo = lo;
        p.saturated = 1'b1;
      end
      comp[i] = quo[CW-1:0];
    end
    p.r_x = comp[0];
    p.r_y = comp[1];
    p.r_z = comp[2];
    return p;
  endfunction

  function automatic logic [IN_W-1:0] pack_vecs(int ux, int uy, int uz, int wx, int wy,
                                                int wz, int vx, int vy, int vz);
    logic [IN_W-1:0] d;
    int f[9];
    f = '{ux, uy, uz, wx, wy, wz, vx, vy, vz};
    d = '0;
    for (int i = 0; i < 9; i++) d[CW*i +: CW] = f[i][CW-1:0];
    return d;
  endfunction

  function automatic int rand_comp(int kind);
    case (kind)
      0: return $signed($urandom_range(2**CW-1)) - 2**(CW-1);
      1: return $signed($urandom_range(64)) - 32;
      default: begin
        case ($urandom_range(3))
          0: return 2**(CW-1) - 1;
          1: return -(2**(CW-1));
          2: return 0;
          default: return $signed($urandom_range(2)) - 1;
        endcase
      end
    endcase
  endfunction

  // random request: mostly general geometry, some parallel or extreme planes
  function automatic logic [IN_W-1:0] rand_request();
    int f[9];
    int kind, k;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++)
      f[i] = rand_comp(kind < 60 ? 0 : (kind < 80 ? 1 : ($urandom_range(1) ? 2 : 0)));
    if (kind >= 90) begin
      // v a small multiple of w so the plane collapses
      k = $signed($urandom_range(4)) - 2;
      for (int i = 0; i < 3; i++) begin
        f[3+i] = f[3+i] / 4;
        f[6+i] = k * f[3+i];
      end
    end
    return pack_vecs(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]);
  endfunction

  task automatic send_request(logic [IN_W-1:0] d, bit typed, proj_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    owed_q.push_back(typed ? res : project_plane(d));
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (owed_q.size() == 0);
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker
  always @(posedge clk_i) begin
    proj_t got, exp_p;
    if (m_axis_tvalid && m_axis_tready) begin
      got.r_x = m_axis_tdata[0 +: CW];
      got.r_y = m_axis_tdata[CW +: CW];
      got.r_z = m_axis_tdata[2*CW +: CW];
      got.degenerate = m_axis_tuser[0];
      got.saturated = m_axis_tuser[1];
      n_got++;
      n_degen += got.degenerate;
      n_clip += got.saturated;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        exp_p = owed_q.pop_front();
        if (got.r_x !== exp_p.r_x) begin
          $display("%0t: r_x expected %h actual %h", $time, exp_p.r_x, got.r_x);
          errors++;
        end
        if (got.r_y !== exp_p.r_y) begin
          $display("%0t: r_y expected %h actual %h", $time, exp_p.r_y, got.r_y);
          errors++;
        end
        if (got.r_z !== exp_p.r_z) begin
          $display("%0t: r_z expected %h actual %h", $time, exp_p.r_z, got.r_z);
          errors++;
        end
        if (got.degenerate !== exp_p.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time,
                   exp_p.degenerate, got.degenerate);
          errors++;
        end
        if (got.saturated !== exp_p.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   exp_p.saturated, got.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int maxv, minv;
    proj_t none, degen;
    maxv = 2**(CW-1) - 1;
    minv = -(2**(CW-1));
    none = '0;
    degen = '0;
    degen.degenerate = 1'b1;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed requests; degenerate rows carry a typed result
    dir_rows.push_back('{pack_vecs(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, degen});
    dir_rows.push_back('{pack_vecs(maxv, minv, 5, 0, 0, 0, 1, 2, 3), 1, degen});
    dir_rows.push_back('{pack_vecs(7, -9, 11, 3, -4, 5, 0, 0, 0), 1, degen});
    dir_rows.push_back('{pack_vecs(minv, minv, minv, maxv, minv, 1, maxv, minv, 1),
                         1, degen});
    dir_rows.push_back('{pack_vecs(maxv, maxv, maxv, 2, 4, 6, -3, -6, -9), 1, degen});
    dir_rows.push_back('{pack_vecs(minv, minv, minv, minv, minv, minv, minv, minv, minv),
                         1, degen});
    dir_rows.push_back('{pack_vecs(maxv, minv, maxv, 1, 0, 0, 0, 1, 0), 0, none});
    dir_rows.push_back('{pack_vecs(minv, maxv, minv, 0, 1, 0, 0, 0, 1), 0, none});
    dir_rows.push_back('{pack_vecs(100, 200, 300, minv, 0, 0, 0, maxv, 0), 0, none});
    // steep plane pushes a component past full scale
    dir_rows.push_back('{pack_vecs(maxv, maxv, minv, 1, 0, 0, 0, 2, -1), 0, none});
    dir_rows.push_back('{pack_vecs(minv, minv, maxv, 1, 0, 0, 0, 2, -1), 0, none});
    dir_rows.push_back('{pack_vecs(maxv, maxv, maxv, maxv, minv, 0, 1, 1, minv), 0, none});
    dir_rows.push_back('{pack_vecs(-1, -1, -1, maxv, maxv, maxv, maxv, maxv, maxv - 1),
                         0, none});
    dir_rows.push_back('{pack_vecs(3, -1, 1, 1, 1, 0, 1, -1, 0), 0, none});
    dir_rows.push_back('{pack_vecs(minv, maxv, 0, minv, minv, minv, maxv, 0, minv), 0, none});
    dir_rows.push_back('{pack_vecs(12345, -2345, 345, -17, 29, 3, 5, 5, -40), 0, none});

    send_idle = 0;
    recv_idle = 0;
    foreach (dir_rows[i]) send_request(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);
    // hold off until the pipeline has emptied
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 48 : 0;
      recv_idle = (ph == 0) ? 48 : (ph == 1) ? 21 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_request(rand_request(), 0, none);
      drain();
    end

    recv_idle = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d results: %0d degenerate planes, %0d clipped",
             n_sent, n_got, n_degen, n_clip);
    $display("three idling mixes, including a full-rate stretch, %0d mismatches", errors);
    if (errors == 0 && owed_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
